[design/wrf_pkg.sv]
// ----------------------------------------------------------------------------
// wrf_pkg
// Shared types and codes of the window rank filter.
// ----------------------------------------------------------------------------
package wrf_pkg;

	localparam int PIX_W = 8;
	localparam int CNT_W = 6;   // window count, up to 49
	localparam int CRD_W = 7;   // coordinate plus one guard bit

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	localparam logic [1:0] MODE_MIN = 2'd0;
	localparam logic [1:0] MODE_MAX = 2'd1;

	typedef enum logic [1:0] {
		REG_MODE   = 2'd0,
		REG_RADIUS = 2'd1,
		REG_WIDTH  = 2'd2,
		REG_HEIGHT = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic       init;    // load rank targets, clear prefixes
		logic       smp;     // sample data valid this cycle
		logic       dec;     // end of pass: settle one bit
		logic [2:0] bitpos;  // bit under decision
	} rank_ctl_t;

endpackage

[design/wrf_store.sv]
// ----------------------------------------------------------------------------
// wrf_store
// Single-port pixel memory with registered read data.
// ----------------------------------------------------------------------------
module wrf_store #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] addr,
	input  logic [23:0]   wdata,
	output logic [23:0]   rdata
);

	logic [23:0] mem [DEPTH];
	logic [23:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;

endmodule

[design/wrf_rank.sv]
// ----------------------------------------------------------------------------
// wrf_rank
// Bitwise radix select: per channel, two rank targets are resolved one bit
// per pass by counting window samples that fall below the candidate prefix.
// ----------------------------------------------------------------------------
module wrf_rank (
	input  logic                    clk,
	input  wrf_pkg::rank_ctl_t      ctl,
	input  logic [wrf_pkg::CNT_W-1:0] k_lo,
	input  logic [wrf_pkg::CNT_W-1:0] k_hi,
	input  logic [23:0]             sample,
	output logic [23:0]             result
);
	import wrf_pkg::*;

	logic [PIX_W-1:0] pfx_q [3][2];
	logic [CNT_W-1:0] k_q   [3][2];
	logic [CNT_W-1:0] cnt_q [3][2];
	logic [PIX_W-1:0] lane_v [3];
	logic [PIX_W-1:0] mask;
	logic             hit [3][2];
	logic [PIX_W:0]   sum [3];

	always_comb begin
		for (int i = 0; i < PIX_W; i++) begin
			mask[i] = (3'(i) > ctl.bitpos);
		end
		for (int ch = 0; ch < 3; ch++) begin
			lane_v[ch] = sample[23 - 8*ch -: 8];
			for (int j = 0; j < 2; j++) begin
				hit[ch][j] = (((lane_v[ch] ^ pfx_q[ch][j]) & mask) == '0) &&
					!lane_v[ch][ctl.bitpos];
			end
			sum[ch] = {1'b0, pfx_q[ch][0]} + {1'b0, pfx_q[ch][1]};
			result[23 - 8*ch -: 8] = sum[ch][PIX_W:1];
		end
	end

	always_ff @(posedge clk) begin
		for (int ch = 0; ch < 3; ch++) begin
			for (int j = 0; j < 2; j++) begin
				if (ctl.init) begin
					pfx_q[ch][j] <= '0;
					k_q[ch][j]   <= (j == 0) ? k_lo : k_hi;
					cnt_q[ch][j] <= '0;
				end else if (ctl.dec) begin
					// at most k below: the bit is set, drop those from k
					if (k_q[ch][j] >= cnt_q[ch][j]) begin
						pfx_q[ch][j][ctl.bitpos] <= 1'b1;
						k_q[ch][j] <= k_q[ch][j] - cnt_q[ch][j];
					end
					cnt_q[ch][j] <= '0;
				end else if (ctl.smp && hit[ch][j]) begin
					cnt_q[ch][j] <= cnt_q[ch][j] + 1'b1;
				end
			end
		end
	end

endmodule

[design/window_rank_filter.sv]
// ----------------------------------------------------------------------------
// window_rank_filter
// RGB pixel store with a per-channel min, max or median window filter on query.
// ----------------------------------------------------------------------------
// channel | signals                                   | direction
// input   | in_valid/in_ready, command col row rgb_in | in
// output  | out_valid/out_ready, rgb_out out_of_range | out
// config  | cfg_valid/cfg_ready, cfg_index cfg_data   | in
//
// A query in range runs eight radix passes over a window of n pixels (up to
// 49), each sweeping the window through the single store port. An out-of-range
// query goes from idle straight to the final state.
// No clearing pass after reset: the store holds garbage until written.
// A waiting result holds the sequencer in its final state until transferred.
// ----------------------------------------------------------------------------
module window_rank_filter #(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64,
	parameter int MAX_RADIUS = 3
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        command,
	input  logic [5:0]  col,
	input  logic [5:0]  row,
	input  logic [7:0]  red_in,
	input  logic [7:0]  green_in,
	input  logic [7:0]  blue_in,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  red_out,
	output logic [7:0]  green_out,
	output logic [7:0]  blue_out,
	output logic        out_of_range,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [6:0]  cfg_data
);
	import wrf_pkg::*;

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_SETUP  = 6'b000010,
		S_SWEEP  = 6'b000100,
		S_DRAIN  = 6'b001000,
		S_DECIDE = 6'b010000,
		S_DONE   = 6'b100000
	} state_t;

	state_t           state_q;
	logic [1:0]       mode_q, radius_q;
	logic [CRD_W-1:0] width_q, height_q;
	logic [CRD_W-1:0] x0_q, x1_q, y0_q, y1_q, x_q, y_q;
	logic [2:0]       bit_q;
	logic             rd_pend_q, oor_q, oor_out_q, out_valid_q;
	logic [23:0]      out_q;

	logic [CRD_W-1:0] w_use, h_use, col_x, row_y, x0, x1, y0, y1;
	logic [1:0]       r_use;
	logic             in_img, in_xfer, load_out;
	logic [3:0]       nx, ny;
	logic [CNT_W-1:0] n, half, k_lo, k_hi;
	logic [AW-1:0]    addr;
	logic [23:0]      rdata, rank_res;
	rank_ctl_t        ctl;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE);
	assign in_xfer   = in_valid && in_ready;

	always_comb begin
		w_use = (32'(width_q) > MAX_WIDTH) ? CRD_W'(MAX_WIDTH) : width_q;
		h_use = (32'(height_q) > MAX_HEIGHT) ? CRD_W'(MAX_HEIGHT) : height_q;
		r_use = (32'(radius_q) > MAX_RADIUS) ? 2'(MAX_RADIUS) : radius_q;
		col_x = {1'b0, col};
		row_y = {1'b0, row};
		in_img = (col_x < w_use) && (row_y < h_use);
		// clip the window at the image borders: left, top, right and bottom
		x0 = (col_x >= CRD_W'(r_use)) ? col_x - CRD_W'(r_use) : '0;
		y0 = (row_y >= CRD_W'(r_use)) ? row_y - CRD_W'(r_use) : '0;
		x1 = (col_x + CRD_W'(r_use) > w_use - 1'b1) ? w_use - 1'b1 : col_x + CRD_W'(r_use);
		y1 = (row_y + CRD_W'(r_use) > h_use - 1'b1) ? h_use - 1'b1 : row_y + CRD_W'(r_use);
	end

	always_comb begin
		nx   = 4'(x1_q - x0_q) + 4'd1;
		ny   = 4'(y1_q - y0_q) + 4'd1;
		n    = CNT_W'(nx) * CNT_W'(ny);
		half = n >> 1;
		if (mode_q == MODE_MIN) begin
			k_lo = '0;
			k_hi = '0;
		end else if (mode_q == MODE_MAX) begin
			k_lo = n - 1'b1;
			k_hi = n - 1'b1;
		end else begin
			k_lo = n[0] ? half : half - 1'b1;
			k_hi = half;
		end
	end

	always_comb begin
		if (state_q == S_SWEEP) begin
			addr = AW'(32'(y_q) * MAX_WIDTH + 32'(x_q));
		end else begin
			addr = AW'(32'(row_y) * MAX_WIDTH + 32'(col_x));
		end
	end

	assign ctl.init   = (state_q == S_SETUP);
	assign ctl.smp    = rd_pend_q;
	assign ctl.dec    = (state_q == S_DECIDE);
	assign ctl.bitpos = bit_q;

	assign load_out = (state_q == S_DONE) && (!out_valid_q || out_ready);

	wrf_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
		.clk   (clk),
		.we    (in_xfer && command == CMD_WRITE && in_img),
		.addr  (addr),
		.wdata ({red_in, green_in, blue_in}),
		.rdata (rdata)
	);

	wrf_rank u_rank (
		.clk    (clk),
		.ctl    (ctl),
		.k_lo   (k_lo),
		.k_hi   (k_hi),
		.sample (rdata),
		.result (rank_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= 2'd2;
			radius_q <= 2'd1;
			width_q  <= 7'd64;
			height_q <= 7'd64;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_MODE:   mode_q   <= cfg_data[1:0];
				REG_RADIUS: radius_q <= cfg_data[1:0];
				REG_WIDTH:  width_q  <= cfg_data;
				REG_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rd_pend_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_pend_q <= (state_q == S_SWEEP);
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_xfer && command == CMD_QUERY) begin
						state_q <= in_img ? S_SETUP : S_DONE;
					end
				end
				S_SETUP:  state_q <= S_SWEEP;
				S_SWEEP: begin
					if (x_q == x1_q && y_q == y1_q) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN:  state_q <= S_DECIDE;
				S_DECIDE: state_q <= (bit_q == 3'd0) ? S_DONE : S_SWEEP;
				S_DONE: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default:  state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			oor_q <= !in_img;
			x0_q  <= x0;
			x1_q  <= x1;
			y0_q  <= y0;
			y1_q  <= y1;
		end
		if (state_q == S_SETUP) begin
			x_q   <= x0_q;
			y_q   <= y0_q;
			bit_q <= 3'd7;
		end else if (state_q == S_SWEEP) begin
			// advance raster over the clipped window
			if (x_q == x1_q) begin
				x_q <= x0_q;
				y_q <= y_q + 1'b1;
			end else begin
				x_q <= x_q + 1'b1;
			end
		end else if (state_q == S_DECIDE) begin
			x_q   <= x0_q;
			y_q   <= y0_q;
			bit_q <= bit_q - 1'b1;
		end
		if (load_out) begin
			out_q     <= oor_q ? 24'd0 : rank_res;
			oor_out_q <= oor_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign red_out      = out_q[23:16];
	assign green_out    = out_q[15:8];
	assign blue_out     = out_q[7:0];
	assign out_of_range = oor_out_q;

endmodule

[design/wrf_checker.sv]
// ----------------------------------------------------------------------------
// wrf_checker
// Port-level checks of the window rank filter, bound to the top level.
// ----------------------------------------------------------------------------
module wrf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       command,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] red_out,
	input logic [7:0] green_out,
	input logic [7:0] blue_out,
	input logic       out_of_range
);
	import wrf_pkg::*;

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && command == CMD_QUERY |=> !in_ready)
		else $error("input taken while a query is in work");

	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_of_range |-> red_out == 8'd0 && green_out == 8'd0 &&
			blue_out == 8'd0)
		else $error("out-of-range result carries data");

	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && command == CMD_WRITE |=> !$rose(out_valid))
		else $error("write transfer produced a result");

endmodule

bind window_rank_filter wrf_checker u_wrf_checker (.*);
